// File: rtl/core/nptc_pkg.sv
package nptc_pkg;

  localparam logic signed [31:0] NearResetZ = 32'sd6554;
  localparam int TStepCount = 16;
  localparam int SqrtStepCount = 24;
  localparam int NormDivStepCount = 38;
  localparam int LerpCompCount = 7;
  localparam int NormCompCount = 3;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [15:0] out_nx;
    logic signed [15:0] out_ny;
    logic signed [15:0] out_nz;
    logic signed [31:0] out_u;
    logic signed [31:0] out_v;
    logic               last_of_polygon;
  } out_beat_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_T_INIT,
    OP_DIV_STEP,
    OP_T_FIN,
    OP_LERP_MUL,
    OP_LERP_ADD,
    OP_SQ_MUL,
    OP_SQ_ADD,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_NDIV_INIT,
    OP_NDIV_FIN,
    OP_EMIT_X,
    OP_EMIT_E
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLIP,
    ST_EDGE,
    ST_T_INIT,
    ST_T_STEP,
    ST_T_FIN,
    ST_LMUL,
    ST_LADD,
    ST_SQMUL,
    ST_SQADD,
    ST_SQRT_INIT,
    ST_SQRT_STEP,
    ST_NDIV_INIT,
    ST_NDIV_STEP,
    ST_NDIV_FIN,
    ST_EMIT_X,
    ST_EMIT_E,
    ST_NEXT
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] edge_idx;
    logic [2:0] k;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] ins;
    logic       out_free;
    logic       acc_zero;
  } status_t;

endpackage

// File: rtl/core/nptc_datapath.sv
module nptc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  nptc_pkg::in_beat_t  in_data_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output nptc_pkg::out_beat_t out_data_o,
  input  nptc_pkg::cmd_t      cmd_i,
  output nptc_pkg::status_t   status_o
);

  nptc_pkg::in_beat_t a_q, b_q, c_q, s_v, e_v;
  logic signed [31:0] near_q;
  logic signed [32:0] near33, zs33, ze33, num, den, an, ad;
  logic               t_zero, t_one;
  logic [16:0]        t_q;
  logic signed [32:0] cs, ce, diff;
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] prod_d, prod_q, rnd;
  logic signed [32:0] lerp_res;
  logic [31:0]        xr_q [4];
  logic signed [15:0] xn_q [3];
  logic signed [15:0] rn_q [3];
  logic [31:0]        acc_q;
  logic [47:0]        sq_src_q;
  logic [27:0]        sq_rem_q, sq_rem_n, sq_trial;
  logic [23:0]        root_q;
  logic [33:0]        div_rem_q, div_rem_n;
  logic [37:0]        div_q;
  logic [32:0]        div_den_q;
  logic [1:0]         t_mode_q;
  logic signed [15:0] nk;
  logic [15:0]        mag;
  logic [37:0]        ndividend;
  logic               out_valid_q;
  nptc_pkg::out_beat_t out_q;

  always_comb begin
    case (cmd_i.edge_idx)
      2'd0: begin s_v = a_q; e_v = b_q; end
      2'd1: begin s_v = b_q; e_v = c_q; end
      default: begin s_v = c_q; e_v = a_q; end
    endcase
  end

  assign near33 = 33'(near_q);
  assign zs33   = 33'(s_v.pos_z);
  assign ze33   = 33'(e_v.pos_z);
  assign num    = near33 - zs33;
  assign den    = ze33 - zs33;
  assign an     = num[32] ? -num : num;
  assign ad     = den[32] ? -den : den;
  assign t_zero = (den == '0) || (num == '0) || (num[32] != den[32]);
  assign t_one  = $unsigned(an) >= $unsigned(ad);

  always_comb begin
    case (cmd_i.k)
      3'd0: begin cs = 33'(s_v.pos_x); ce = 33'(e_v.pos_x); end
      3'd1: begin cs = 33'(s_v.pos_y); ce = 33'(e_v.pos_y); end
      3'd2: begin cs = 33'(s_v.tex_u); ce = 33'(e_v.tex_u); end
      3'd3: begin cs = 33'(s_v.tex_v); ce = 33'(e_v.tex_v); end
      3'd4: begin cs = 33'(s_v.norm_x); ce = 33'(e_v.norm_x); end
      3'd5: begin cs = 33'(s_v.norm_y); ce = 33'(e_v.norm_y); end
      default: begin cs = 33'(s_v.norm_z); ce = 33'(e_v.norm_z); end
    endcase
  end

  assign diff = ce - cs;
  assign nk   = xn_q[cmd_i.k[1:0]];
  assign mag  = nk[15] ? 16'(-17'(nk)) : 16'(nk);
  assign ndividend = {mag, 22'b0} + {15'b0, root_q[23:1]};

  always_comb begin
    if (cmd_i.op == nptc_pkg::OP_SQ_MUL) begin
      mul_a = 33'(nk);
      mul_b = 18'(nk);
    end else begin
      mul_a = diff;
      mul_b = $signed({1'b0, t_q});
    end
  end

  assign prod_d   = mul_a * mul_b;
  assign rnd      = (prod_q + 51'sd32768) >>> 16;
  assign lerp_res = cs + rnd[32:0];

  assign sq_rem_n = {sq_rem_q[25:0], sq_src_q[47:46]};
  assign sq_trial = {2'b0, root_q, 2'b01};
  assign div_rem_n = {div_rem_q[32:0], div_q[37]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q      <= nptc_pkg::NearResetZ;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        near_q <= cfg_wdata_i;
      end
      if (cmd_i.op == nptc_pkg::OP_EMIT_X || cmd_i.op == nptc_pkg::OP_EMIT_E) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      nptc_pkg::OP_LOAD: begin
        case (cmd_i.k[1:0])
          2'd0: a_q <= in_data_i;
          2'd1: b_q <= in_data_i;
          default: c_q <= in_data_i;
        endcase
      end
      nptc_pkg::OP_T_INIT: begin
        t_mode_q  <= t_zero ? 2'd0 : (t_one ? 2'd1 : 2'd2);
        div_rem_q <= {1'b0, an};
        div_q     <= '0;
        div_den_q <= ad;
      end
      nptc_pkg::OP_DIV_STEP: begin
        if (div_rem_n >= {1'b0, div_den_q}) begin
          div_rem_q <= div_rem_n - {1'b0, div_den_q};
          div_q     <= {div_q[36:0], 1'b1};
        end else begin
          div_rem_q <= div_rem_n;
          div_q     <= {div_q[36:0], 1'b0};
        end
      end
      nptc_pkg::OP_T_FIN: begin
        case (t_mode_q)
          2'd0: t_q <= '0;
          2'd1: t_q <= 17'h10000;
          default: t_q <= {1'b0, div_q[15:0]};
        endcase
        acc_q <= '0;
      end
      nptc_pkg::OP_LERP_MUL, nptc_pkg::OP_SQ_MUL: begin
        prod_q <= prod_d;
      end
      nptc_pkg::OP_LERP_ADD: begin
        if (cmd_i.k < 3'd4) begin
          xr_q[cmd_i.k[1:0]] <= lerp_res[31:0];
        end else begin
          xn_q[2'(cmd_i.k - 3'd4)] <= lerp_res[15:0];
        end
      end
      nptc_pkg::OP_SQ_ADD: begin
        acc_q <= acc_q + prod_q[31:0];
      end
      nptc_pkg::OP_SQRT_INIT: begin
        sq_src_q <= {acc_q, 16'b0};
        sq_rem_q <= '0;
        root_q   <= '0;
        if (acc_q == '0) begin
          rn_q[0] <= '0;
          rn_q[1] <= '0;
          rn_q[2] <= '0;
        end
      end
      nptc_pkg::OP_SQRT_STEP: begin
        sq_src_q <= {sq_src_q[45:0], 2'b0};
        if (sq_rem_n >= sq_trial) begin
          sq_rem_q <= sq_rem_n - sq_trial;
          root_q   <= {root_q[22:0], 1'b1};
        end else begin
          sq_rem_q <= sq_rem_n;
          root_q   <= {root_q[22:0], 1'b0};
        end
      end
      nptc_pkg::OP_NDIV_INIT: begin
        div_rem_q <= '0;
        div_q     <= ndividend;
        div_den_q <= {9'b0, root_q};
      end
      nptc_pkg::OP_NDIV_FIN: begin
        if (nk[15]) begin
          rn_q[cmd_i.k[1:0]] <= (div_q > 38'd32768) ? -16'sd32768 : 16'(-div_q[16:0]);
        end else begin
          rn_q[cmd_i.k[1:0]] <= (div_q > 38'd32767) ? 16'sd32767 : div_q[15:0];
        end
      end
      nptc_pkg::OP_EMIT_X: begin
        out_q.out_x           <= xr_q[0];
        out_q.out_y           <= xr_q[1];
        out_q.out_z           <= near_q;
        out_q.out_nx          <= rn_q[0];
        out_q.out_ny          <= rn_q[1];
        out_q.out_nz          <= rn_q[2];
        out_q.out_u           <= xr_q[2];
        out_q.out_v           <= xr_q[3];
        out_q.last_of_polygon <= cmd_i.last;
      end
      nptc_pkg::OP_EMIT_E: begin
        out_q.out_x           <= e_v.pos_x;
        out_q.out_y           <= e_v.pos_y;
        out_q.out_z           <= e_v.pos_z;
        out_q.out_nx          <= e_v.norm_x;
        out_q.out_ny          <= e_v.norm_y;
        out_q.out_nz          <= e_v.norm_z;
        out_q.out_u           <= e_v.tex_u;
        out_q.out_v           <= e_v.tex_v;
        out_q.last_of_polygon <= cmd_i.last;
      end
      default: ;
    endcase
  end

  assign status_o.ins[0]  = a_q.pos_z >= near_q;
  assign status_o.ins[1]  = b_q.pos_z >= near_q;
  assign status_o.ins[2]  = c_q.pos_z >= near_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign status_o.acc_zero = acc_q == '0;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/nptc_ctrl.sv
module nptc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  nptc_pkg::status_t status_i,
  output nptc_pkg::cmd_t    cmd_o
);

  nptc_pkg::state_e state_q, state_d;
  logic [1:0] vcnt_q, vcnt_d, edge_q, edge_d, e_idx;
  logic [5:0] cnt_q, cnt_d;
  logic [2:0] k_q, k_d, total_q, total_d, emit_q, emit_d;
  logic       s_in, e_in;

  assign e_idx = (edge_q == 2'd2) ? 2'd0 : edge_q + 2'd1;
  assign s_in  = status_i.ins[edge_q];
  assign e_in  = status_i.ins[e_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nptc_pkg::ST_IDLE;
      vcnt_q  <= '0;
      edge_q  <= '0;
      cnt_q   <= '0;
      k_q     <= '0;
      total_q <= '0;
      emit_q  <= '0;
    end else begin
      state_q <= state_d;
      vcnt_q  <= vcnt_d;
      edge_q  <= edge_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      total_q <= total_d;
      emit_q  <= emit_d;
    end
  end

  always_comb begin
    state_d = state_q;
    vcnt_d  = vcnt_q;
    edge_d  = edge_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    total_d = total_q;
    emit_d  = emit_q;
    cmd_o.op       = nptc_pkg::OP_NONE;
    cmd_o.edge_idx = edge_q;
    cmd_o.k        = k_q;
    cmd_o.last     = (emit_q + 3'd1) == total_q;
    in_stall_o     = state_q != nptc_pkg::ST_IDLE;
    case (state_q)
      nptc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = nptc_pkg::OP_LOAD;
          cmd_o.k  = {1'b0, vcnt_q};
          if (vcnt_q == 2'd2) begin
            vcnt_d  = '0;
            state_d = nptc_pkg::ST_CLIP;
          end else begin
            vcnt_d = vcnt_q + 2'd1;
          end
        end
      end
      nptc_pkg::ST_CLIP: begin
        total_d = '0;
        for (int i = 0; i < 3; i++) begin
          if (status_i.ins[i] && status_i.ins[(i + 1) % 3]) begin
            total_d = total_d + 3'd1;
          end else if (status_i.ins[i]) begin
            total_d = total_d + 3'd1;
          end else if (status_i.ins[(i + 1) % 3]) begin
            total_d = total_d + 3'd2;
          end
        end
        emit_d  = '0;
        edge_d  = '0;
        state_d = nptc_pkg::ST_EDGE;
      end
      nptc_pkg::ST_EDGE: begin
        if (s_in && e_in) begin
          state_d = nptc_pkg::ST_EMIT_E;
        end else if (s_in || e_in) begin
          state_d = nptc_pkg::ST_T_INIT;
        end else begin
          state_d = nptc_pkg::ST_NEXT;
        end
      end
      nptc_pkg::ST_T_INIT: begin
        cmd_o.op = nptc_pkg::OP_T_INIT;
        cnt_d    = '0;
        state_d  = nptc_pkg::ST_T_STEP;
      end
      nptc_pkg::ST_T_STEP: begin
        cmd_o.op = nptc_pkg::OP_DIV_STEP;
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == 6'(nptc_pkg::TStepCount - 1)) begin
          state_d = nptc_pkg::ST_T_FIN;
        end
      end
      nptc_pkg::ST_T_FIN: begin
        cmd_o.op = nptc_pkg::OP_T_FIN;
        k_d      = '0;
        state_d  = nptc_pkg::ST_LMUL;
      end
      nptc_pkg::ST_LMUL: begin
        cmd_o.op = nptc_pkg::OP_LERP_MUL;
        state_d  = nptc_pkg::ST_LADD;
      end
      nptc_pkg::ST_LADD: begin
        cmd_o.op = nptc_pkg::OP_LERP_ADD;
        if (k_q == 3'(nptc_pkg::LerpCompCount - 1)) begin
          k_d     = '0;
          state_d = nptc_pkg::ST_SQMUL;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = nptc_pkg::ST_LMUL;
        end
      end
      nptc_pkg::ST_SQMUL: begin
        cmd_o.op = nptc_pkg::OP_SQ_MUL;
        state_d  = nptc_pkg::ST_SQADD;
      end
      nptc_pkg::ST_SQADD: begin
        cmd_o.op = nptc_pkg::OP_SQ_ADD;
        if (k_q == 3'(nptc_pkg::NormCompCount - 1)) begin
          state_d = nptc_pkg::ST_SQRT_INIT;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = nptc_pkg::ST_SQMUL;
        end
      end
      nptc_pkg::ST_SQRT_INIT: begin
        cmd_o.op = nptc_pkg::OP_SQRT_INIT;
        cnt_d    = '0;
        k_d      = '0;
        state_d  = status_i.acc_zero ? nptc_pkg::ST_EMIT_X : nptc_pkg::ST_SQRT_STEP;
      end
      nptc_pkg::ST_SQRT_STEP: begin
        cmd_o.op = nptc_pkg::OP_SQRT_STEP;
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == 6'(nptc_pkg::SqrtStepCount - 1)) begin
          state_d = nptc_pkg::ST_NDIV_INIT;
        end
      end
      nptc_pkg::ST_NDIV_INIT: begin
        cmd_o.op = nptc_pkg::OP_NDIV_INIT;
        cnt_d    = '0;
        state_d  = nptc_pkg::ST_NDIV_STEP;
      end
      nptc_pkg::ST_NDIV_STEP: begin
        cmd_o.op = nptc_pkg::OP_DIV_STEP;
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == 6'(nptc_pkg::NormDivStepCount - 1)) begin
          state_d = nptc_pkg::ST_NDIV_FIN;
        end
      end
      nptc_pkg::ST_NDIV_FIN: begin
        cmd_o.op = nptc_pkg::OP_NDIV_FIN;
        if (k_q == 3'(nptc_pkg::NormCompCount - 1)) begin
          state_d = nptc_pkg::ST_EMIT_X;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = nptc_pkg::ST_NDIV_INIT;
        end
      end
      nptc_pkg::ST_EMIT_X: begin
        if (status_i.out_free) begin
          cmd_o.op = nptc_pkg::OP_EMIT_X;
          emit_d   = emit_q + 3'd1;
          state_d  = s_in ? nptc_pkg::ST_NEXT : nptc_pkg::ST_EMIT_E;
        end
      end
      nptc_pkg::ST_EMIT_E: begin
        if (status_i.out_free) begin
          cmd_o.op = nptc_pkg::OP_EMIT_E;
          emit_d   = emit_q + 3'd1;
          state_d  = nptc_pkg::ST_NEXT;
        end
      end
      nptc_pkg::ST_NEXT: begin
        if (edge_q == 2'd2) begin
          state_d = nptc_pkg::ST_IDLE;
        end else begin
          edge_d  = edge_q + 2'd1;
          state_d = nptc_pkg::ST_EDGE;
        end
      end
      default: state_d = nptc_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: rtl/core/near_plane_triangle_clipper_unit.sv
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   in_data_i   (one vertex)
// out      output     out_valid_o / out_stall_i out_data_o  (one clipped vertex)
// cfg      input      cfg_we_i                  cfg_wdata_i (near plane z)
// Vertices one and two of a triangle are only loaded; the third starts the clip.
// Each crossing edge runs on the shared divider, square root and multiplier; the
// square root and normal divide are skipped when the interpolated normal is zero.
// Reset clears control and sets the near plane; the input stalls while clipping.
// A stalled output holds its beat; the clipper waits on it before the next one.
module near_plane_triangle_clipper_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  nptc_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output nptc_pkg::out_beat_t out_data_o
);

  nptc_pkg::cmd_t    cmd;
  nptc_pkg::status_t status;

  nptc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  nptc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// File: tb/sv/near_plane_triangle_clipper_unit_test.sv
module near_plane_triangle_clipper_unit_test;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  nptc_pkg::in_beat_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  nptc_pkg::out_beat_t out_data_o;

  near_plane_triangle_clipper_unit u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .in_data_i, .out_valid_o, .out_stall_i, .out_data_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic signed [31:0] near_z = nptc_pkg::NearResetZ;
  nptc_pkg::in_beat_t   held_vtx [2];
  int         vtx_count = 0;
  nptc_pkg::out_beat_t  clipped_q[$];
  int         err_count = 0;
  bit         stall_idle_ok = 1'b1;

  typedef struct {
    longint p[3];
    longint n[3];
    longint tc[2];
  } vert_t;

  function automatic vert_t unpack_vtx(nptc_pkg::in_beat_t b);
    vert_t v;
    v.p[0] = longint'(b.pos_x);  v.p[1] = longint'(b.pos_y);
    v.p[2] = longint'(b.pos_z);
    v.n[0] = longint'(b.norm_x); v.n[1] = longint'(b.norm_y);
    v.n[2] = longint'(b.norm_z);
    v.tc[0] = longint'(b.tex_u); v.tc[1] = longint'(b.tex_v);
    return v;
  endfunction

  function automatic longint lerp(longint s, longint e, longint t);
    longint prod;
    prod = (e - s) * t + 32768;
    return s + (prod >>> 16);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic vert_t cross_near(vert_t s, vert_t e);
    vert_t o;
    longint num, den, t, an, ad, len2, len, mag, q, r;
    num = longint'(near_z) - s.p[2];
    den = e.p[2] - s.p[2];
    if (den == 0 || num == 0 || ((num < 0) != (den < 0))) begin
      t = 0;
    end else begin
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      t = (an >= ad) ? 65536 : (an << 16) / ad;
    end
    for (int i = 0; i < 3; i++) begin
      o.p[i] = lerp(s.p[i], e.p[i], t);
      o.n[i] = lerp(s.n[i], e.n[i], t);
    end
    o.p[2] = longint'(near_z);
    for (int i = 0; i < 2; i++) o.tc[i] = lerp(s.tc[i], e.tc[i], t);
    len2 = o.n[0] * o.n[0] + o.n[1] * o.n[1] + o.n[2] * o.n[2];
    if (len2 == 0) begin
      for (int i = 0; i < 3; i++) o.n[i] = 0;
    end else begin
      len = int_sqrt(len2 << 16);
      for (int i = 0; i < 3; i++) begin
        mag = o.n[i] < 0 ? -o.n[i] : o.n[i];
        q = ((mag << 22) + len / 2) / len;
        r = o.n[i] < 0 ? -q : q;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        o.n[i] = r;
      end
    end
    return o;
  endfunction

  function automatic nptc_pkg::out_beat_t to_beat(vert_t v);
    nptc_pkg::out_beat_t b;
    b.out_x = 32'(v.p[0]);  b.out_y = 32'(v.p[1]);  b.out_z = 32'(v.p[2]);
    b.out_nx = 16'(v.n[0]); b.out_ny = 16'(v.n[1]); b.out_nz = 16'(v.n[2]);
    b.out_u = 32'(v.tc[0]); b.out_v = 32'(v.tc[1]);
    b.last_of_polygon = 1'b0;
    return b;
  endfunction

  function automatic void expect_beat(nptc_pkg::out_beat_t b);
    clipped_q.insert(clipped_q.size(), b);
  endfunction

  task automatic predict_clip(nptc_pkg::in_beat_t b);
    vert_t v[3];
    vert_t s, e;
    bit si, ei;
    int k;
    if (vtx_count < 2) begin
      held_vtx[vtx_count] = b;
      vtx_count++;
      return;
    end
    vtx_count = 0;
    v[0] = unpack_vtx(held_vtx[0]);
    v[1] = unpack_vtx(held_vtx[1]);
    v[2] = unpack_vtx(b);
    k = 0;
    for (int i = 0; i < 3; i++) begin
      s = v[i];
      e = v[(i + 1) % 3];
      si = s.p[2] >= longint'(near_z);
      ei = e.p[2] >= longint'(near_z);
      if (si && ei) begin
        expect_beat(to_beat(e)); k++;
      end else if (si) begin
        expect_beat(to_beat(cross_near(s, e))); k++;
      end else if (ei) begin
        expect_beat(to_beat(cross_near(s, e)));
        expect_beat(to_beat(e)); k += 2;
      end
    end
    if (k > 0) clipped_q[$].last_of_polygon = 1'b1;
  endtask

  // checker and output stall
  int stall_left = 0;
  always @(posedge clk_i) begin
    nptc_pkg::out_beat_t x;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (clipped_q.size() == 0) begin
        $error("unexpected beat %p", out_data_o);
        err_count++;
      end else begin
        x = clipped_q.pop_front();
        if (x.out_x !== out_data_o.out_x) begin
          $error("out_x exp %0d got %0d", x.out_x, out_data_o.out_x); err_count++;
        end
        if (x.out_y !== out_data_o.out_y) begin
          $error("out_y exp %0d got %0d", x.out_y, out_data_o.out_y); err_count++;
        end
        if (x.out_z !== out_data_o.out_z) begin
          $error("out_z exp %0d got %0d", x.out_z, out_data_o.out_z); err_count++;
        end
        if (x.out_nx !== out_data_o.out_nx) begin
          $error("out_nx exp %0d got %0d", x.out_nx, out_data_o.out_nx); err_count++;
        end
        if (x.out_ny !== out_data_o.out_ny) begin
          $error("out_ny exp %0d got %0d", x.out_ny, out_data_o.out_ny); err_count++;
        end
        if (x.out_nz !== out_data_o.out_nz) begin
          $error("out_nz exp %0d got %0d", x.out_nz, out_data_o.out_nz); err_count++;
        end
        if (x.out_u !== out_data_o.out_u) begin
          $error("out_u exp %0d got %0d", x.out_u, out_data_o.out_u); err_count++;
        end
        if (x.out_v !== out_data_o.out_v) begin
          $error("out_v exp %0d got %0d", x.out_v, out_data_o.out_v); err_count++;
        end
        if (x.last_of_polygon !== out_data_o.last_of_polygon) begin
          $error("last_of_polygon exp %0b got %0b", x.last_of_polygon,
                 out_data_o.last_of_polygon);
          err_count++;
        end
      end
    end
  end

  // stall is redrawn per beat, at random length
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (out_stall_i == 1'b0 && out_valid_o && stall_idle_ok) begin
      stall_left = $urandom_range(0, 15);
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  bit quiet_sender = 1'b0;

  task automatic send_vertex(nptc_pkg::in_beat_t b);
    int gap;
    gap = quiet_sender ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i <= b;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_clip(b);
    @(negedge clk_i);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (clipped_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (1000) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_near(logic signed [31:0] z);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= z;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    near_z = z;
  endtask

  function automatic nptc_pkg::in_beat_t rand_vertex(int zmode);
    nptc_pkg::in_beat_t b;
    b.pos_x = $urandom; b.pos_y = $urandom;
    b.tex_u = $urandom; b.tex_v = $urandom;
    b.norm_x = 16'($urandom); b.norm_y = 16'($urandom); b.norm_z = 16'($urandom);
    case (zmode)
      0: b.pos_z = $urandom;
      1: b.pos_z = near_z + $signed($urandom_range(0, 400000)) - 200000;
      default: b.pos_z = near_z + $signed($urandom_range(0, 8)) - 4;
    endcase
    if ($urandom_range(0, 3) == 0) begin
      b.pos_x = $signed(b.pos_x) >>> 12; b.pos_y = $signed(b.pos_y) >>> 12;
      b.norm_x = $signed(b.norm_x) >>> 2; b.norm_y = $signed(b.norm_y) >>> 2;
      b.norm_z = $signed(b.norm_z) >>> 2;
    end
    return b;
  endfunction

  function automatic nptc_pkg::in_beat_t mk(logic signed [31:0] x,
                                            logic signed [31:0] z,
                                            logic signed [15:0] nz);
    nptc_pkg::in_beat_t b;
    b = '0;
    b.pos_x = x; b.pos_y = -x; b.pos_z = z;
    b.norm_x = '0; b.norm_y = 16'sd16384; b.norm_z = nz;
    b.tex_u = x <<< 1; b.tex_v = 32'sh7fff_ffff - x;
    return b;
  endfunction

  task automatic test_directed;
    // all inside, all outside, one out, two out, zero depth step, zero normal
    send_vertex(mk(0, 32'sd100000, 16384));
    send_vertex(mk(65536, 32'sd200000, 0));
    send_vertex(mk(-65536, 32'sd6554, -16384));
    send_vertex(mk(1, -32'sd100000, 0));
    send_vertex(mk(2, -32'sd200000, 0));
    send_vertex(mk(3, 32'sd6553, 0));
    send_vertex(mk(32'sh7fff_ffff, 32'sh7fff_ffff, 16'sh7fff));
    send_vertex(mk(32'sh8000_0000, 32'sh8000_0000, 16'sh8000));
    send_vertex(mk(12345, 32'sd6554, 0));
    send_vertex(mk(500, -32'sd1000, 0));
    send_vertex(mk(600, 32'sd9000, 0));
    send_vertex(mk(700, 32'sd8000, 0));
    begin
      nptc_pkg::in_beat_t z0, z1, z2;
      z0 = mk(10, 32'sd0, 0); z0.norm_y = 0;
      z1 = mk(20, 32'sd10000, 0); z1.norm_y = 0;
      z2 = mk(30, 32'sd0, 0); z2.norm_y = 0;
      send_vertex(z0); send_vertex(z1); send_vertex(z2);
      z0 = rand_vertex(0); z0.pos_z = 32'sh8000_0000;
      z1 = rand_vertex(0); z1.pos_z = 32'sh7fff_ffff;
      z2 = rand_vertex(0); z2.pos_z = 32'sh8000_0000;
      z2.pos_x = 32'sh8000_0000; z2.tex_v = 32'sh7fff_ffff;
      send_vertex(z0); send_vertex(z1); send_vertex(z2);
    end
    send_vertex(mk(-7, 32'sd6554, 0));
    send_vertex(mk(-8, 32'sd6554, 0));
    send_vertex(mk(-9, 32'sd6554, 0));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_vertex(rand_vertex($urandom_range(0, 2)));
  endtask

  task automatic test_config_extremes;
    write_near(32'sh8000_0000);
    test_random(12);
    drain();
    write_near(32'sh7fff_ffff);
    test_random(12);
    drain();
    write_near(-32'sd65536);
    test_random(12);
    drain();
  endtask

  task automatic test_paused_sender;
    quiet_sender = 1'b1;
    stall_idle_ok = 1'b0;
    test_random(21);
    quiet_sender = 1'b0;
    stall_idle_ok = 1'b1;
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    drain();
    test_random(60);
    drain();
    test_paused_sender();
    test_config_extremes();
    write_near($urandom);
    test_random(45);
    drain();
    write_near(32'sd6554);
    test_random(30);
    drain();
    if (err_count == 0 && clipped_q.size() == 0) begin
      $display("near_plane_triangle_clipper_unit_test: done, clean");
    end else begin
      if (clipped_q.size() != 0) $error("%0d beats never arrived", clipped_q.size());
      $display("near_plane_triangle_clipper_unit_test: done, errors");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("near_plane_triangle_clipper_unit_test: done, errors");
    $finish;
  end

endmodule
